/* src/olaq_pkg.sv */
// ----------------------------------------------------------------------------
// olaq_pkg
// Shared types and codes for the oxygen leak alarm qualifier.
// ----------------------------------------------------------------------------
package olaq_pkg;

	localparam int unsigned FlowW   = 16;
	localparam int unsigned Fio2W   = 7;
	localparam int unsigned HoldW   = 16;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgDatW = 16;

	// register indexes on the configuration port
	localparam logic [CfgIdxW-1:0] CFG_LEAK_THRESHOLD = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_FIO2_MINIMUM   = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_HOLD_TICKS     = 2'd2;

	// values after reset
	localparam logic signed [FlowW-1:0] LEAK_THRESHOLD_RST = 16'sd50;
	localparam logic [Fio2W-1:0]        FIO2_MINIMUM_RST   = 7'd21;
	localparam logic [HoldW-1:0]        HOLD_TICKS_RST     = 16'd10000;

	typedef enum logic {
		ACT_TICK = 1'b0,
		ACT_EVAL = 1'b1
	} item_action_t;

	typedef enum logic [2:0] {
		VENT_DISABLED  = 3'd0,
		VENT_INSP_CTRL = 3'd1,
		VENT_INSP_TRIG = 3'd2,
		VENT_EXHALE    = 3'd3
	} vent_state_t;

	typedef enum logic [2:0] {
		AL_FALSE     = 3'd0,
		AL_DETECTED  = 3'd1,
		AL_TRUE      = 3'd2,
		AL_DISPLAYED = 3'd3,
		AL_CANCELED  = 3'd4
	} alarm_state_t;

	typedef enum logic [1:0] {
		ALARM_NONE  = 2'd0,
		ALARM_RAISE = 2'd1,
		ALARM_END   = 2'd2
	} alarm_action_t;

	typedef struct packed {
		logic signed [FlowW-1:0] leak_threshold;
		logic [Fio2W-1:0]        fio2_minimum;
		logic [HoldW-1:0]        hold_ticks;
	} olaq_cfg_t;

	typedef struct packed {
		logic signed [FlowW-1:0] peak_flow;
		logic [2:0]              last_vent_state;
		logic [HoldW-1:0]        hold_countdown;
	} olaq_state_t;

	typedef struct packed {
		logic [1:0] alarm_action;
		logic       state_error;
	} olaq_result_t;

endpackage

/* src/olaq_eval.sv */
// ----------------------------------------------------------------------------
// olaq_eval
// Next-state and alarm decision logic for one input item.
// ----------------------------------------------------------------------------
module olaq_eval
	import olaq_pkg::*;
(
	input  logic                    action,
	input  logic [2:0]              alarm_state,
	input  logic [2:0]              vent_state,
	input  logic signed [FlowW-1:0] o2_flow,
	input  logic [Fio2W-1:0]        fio2_setting,
	input  logic                    full_o2_active,
	input  olaq_cfg_t               cfg,
	input  olaq_state_t             cur,
	output olaq_state_t             nxt,
	output olaq_result_t            res
);

	logic                    insp;
	logic                    last_insp;
	logic                    end_of_insp;
	logic                    fio2_on;
	logic                    vent_off;
	logic signed [FlowW-1:0] peak_base;
	logic signed [FlowW-1:0] peak_new;
	logic [HoldW-1:0]        hold_new;
	logic                    raise;
	logic                    stop;

	assign insp      = (vent_state == VENT_INSP_CTRL) || (vent_state == VENT_INSP_TRIG);
	assign last_insp = (cur.last_vent_state == VENT_INSP_CTRL)
	                || (cur.last_vent_state == VENT_INSP_TRIG);
	assign vent_off  = (vent_state == VENT_DISABLED);
	assign end_of_insp = (vent_state == VENT_EXHALE) && last_insp;
	assign fio2_on   = fio2_setting > cfg.fio2_minimum;

	// new inspiration after exhalation starts the peak afresh
	assign peak_base = (insp && cur.last_vent_state == VENT_EXHALE) ? '0 : cur.peak_flow;
	assign peak_new  = (insp && o2_flow > peak_base) ? o2_flow : peak_base;
	assign hold_new  = fio2_on ? cfg.hold_ticks : cur.hold_countdown;

	assign raise = (peak_new >= cfg.leak_threshold && !full_o2_active && !fio2_on
	                && hold_new == '0 && end_of_insp)
	            || (vent_off && o2_flow > cfg.leak_threshold);
	assign stop  = (peak_new < cfg.leak_threshold && end_of_insp)
	            || (fio2_on && !vent_off) || full_o2_active
	            || (o2_flow <= cfg.leak_threshold && vent_off);

	always_comb begin
		nxt = cur;
		res = '{alarm_action: ALARM_NONE, state_error: 1'b0};
		unique case (item_action_t'(action))
			ACT_TICK: begin
				if (cur.hold_countdown != '0) begin
					nxt.hold_countdown = cur.hold_countdown - 1'b1;
				end
			end
			ACT_EVAL: begin
				nxt.peak_flow       = peak_new;
				nxt.hold_countdown  = hold_new;
				nxt.last_vent_state = vent_state;
				unique case (alarm_state)
					AL_FALSE:     res.alarm_action = raise ? ALARM_RAISE : ALARM_NONE;
					AL_DISPLAYED: res.alarm_action = stop ? ALARM_END : ALARM_NONE;
					AL_TRUE:      res.alarm_action = ALARM_NONE;
					default:      res.state_error  = 1'b1;
				endcase
			end
			default: nxt = cur;
		endcase
	end

endmodule

/* src/oxygen_leak_alarm_qualifier.sv */
// ----------------------------------------------------------------------------
// oxygen_leak_alarm_qualifier
// Qualifies the oxygen leak alarm from timer ticks and check-cycle evaluations.
// ----------------------------------------------------------------------------
// One input item is taken every clock cycle while in_ready is high. A tick
// counts the hold timer down (stopping at zero) and gives no result; an
// evaluation updates the inspiration peak flow, reloads the hold timer while
// FiO2 is above its minimum, and gives one result: alarm_action and
// state_error. The state is updated at the input transfer itself, so
// back-to-back items always see the work of the one before. The result of an
// evaluation is registered at its transfer. Results sit in a two-entry output
// buffer (output register plus skid register): in_ready drops only when both
// entries hold a result that the consumer has not taken, and in_ready is a
// register output with no combinational path from out_ready. Configuration
// writes are taken in any cycle (cfg_ready is always high) and must only be
// made while the block is idle; indexes beyond the register list are ignored.
// ----------------------------------------------------------------------------
module oxygen_leak_alarm_qualifier
	import olaq_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	// item input
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      action,
	input  logic [2:0]                alarm_state,
	input  logic [2:0]                vent_state,
	input  logic signed [FlowW-1:0]   o2_flow,
	input  logic [Fio2W-1:0]          fio2_setting,
	input  logic                      full_o2_active,
	// result output
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                alarm_action,
	output logic                      state_error,
	// configuration writes
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CfgIdxW-1:0]        cfg_index,
	input  logic [CfgDatW-1:0]        cfg_data
);

	olaq_cfg_t    cfg_q;
	olaq_state_t  state_q;
	olaq_state_t  state_nxt;
	olaq_result_t res_new;
	olaq_result_t out_q;
	olaq_result_t skid_q;
	logic         out_valid_q;
	logic         skid_valid_q;
	logic         in_xfer;
	logic         push;
	logic         pop;

	assign cfg_ready = 1'b1;
	assign in_ready  = !skid_valid_q;
	assign in_xfer   = in_valid && in_ready;
	assign push      = in_xfer && (item_action_t'(action) == ACT_EVAL);
	assign pop       = out_valid_q && out_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.leak_threshold <= LEAK_THRESHOLD_RST;
			cfg_q.fio2_minimum   <= FIO2_MINIMUM_RST;
			cfg_q.hold_ticks     <= HOLD_TICKS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_LEAK_THRESHOLD: cfg_q.leak_threshold <= cfg_data;
				CFG_FIO2_MINIMUM:   cfg_q.fio2_minimum   <= cfg_data[Fio2W-1:0];
				CFG_HOLD_TICKS:     cfg_q.hold_ticks     <= cfg_data[HoldW-1:0];
				default: ;
			endcase
		end
	end

	// single-pass decision: state and result both follow from the transfer
	olaq_eval u_eval (
		.action         (action),
		.alarm_state    (alarm_state),
		.vent_state     (vent_state),
		.o2_flow        (o2_flow),
		.fio2_setting   (fio2_setting),
		.full_o2_active (full_o2_active),
		.cfg            (cfg_q),
		.cur            (state_q),
		.nxt            (state_nxt),
		.res            (res_new)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{peak_flow: '0, last_vent_state: VENT_DISABLED, hold_countdown: '0};
		end else if (in_xfer) begin
			state_q <= state_nxt;
		end
	end

	// output buffer: the output register drains from the skid first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			out_q <= skid_valid_q ? skid_q : res_new;
		end
		if (push && out_valid_q && !pop) begin
			skid_q <= res_new;
		end
	end

	assign out_valid    = out_valid_q;
	assign alarm_action = out_q.alarm_action;
	assign state_error  = out_q.state_error;

endmodule

/* src/olaq_checker.sv */
// ----------------------------------------------------------------------------
// olaq_checker
// Port-level checks on the leak alarm qualifier, bound to the top level.
// ----------------------------------------------------------------------------
module olaq_checker
	import olaq_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       action,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] alarm_action,
	input logic       state_error
);

	// a waiting result keeps its fields
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(alarm_action) && $stable(state_error))
		else $error("result changed while waiting");

	// an error result never carries an alarm action
	a_err_none: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && state_error |-> alarm_action == ALARM_NONE)
		else $error("state error with alarm action");

	a_act_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> alarm_action == ALARM_NONE || alarm_action == ALARM_RAISE
		           || alarm_action == ALARM_END)
		else $error("undefined alarm action code");

	// back-pressure only once the output holds a result
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output");

	// an evaluation into an empty output shows up on the next cycle
	a_eval_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && action && !out_valid |=> out_valid)
		else $error("evaluation result missing");

endmodule

bind oxygen_leak_alarm_qualifier olaq_checker u_olaq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.action       (action),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.alarm_action (alarm_action),
	.state_error  (state_error)
);

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the oxygen leak alarm qualifier: a queue-fed driver
// offers ticks and evaluations, a behavioural predictor works out the alarm
// verdict of every accepted evaluation, and a monitor compares each result
// transfer with the oldest outstanding verdict.
// ----------------------------------------------------------------------------
module tb_top;
	import olaq_pkg::*;

	localparam int HALF_PERIOD    = 5;
	localparam int RESET_CYCLES   = 2;
	localparam int CYCLE_LIMIT    = 200000;
	localparam int IDLE_GAP       = 6;     // result is registered at its transfer
	localparam int RX_HOLD_CYCLES = 80;    // long enough to fill the output buffer
	localparam int NUM_CHUNKS     = 9;
	localparam int CHUNK_ITEMS    = 148;
	localparam int NUM_SETTINGS   = 6;
	localparam int MAX_REPORTS    = 10;

	// codes outside the package enums
	localparam logic [CfgIdxW-1:0] CFG_SPARE        = 2'd3;  // no register here
	localparam logic [2:0]         VENT_OTHER_FIRST = 3'd4;
	localparam logic [2:0]         VENT_OTHER_LAST  = 3'd7;
	localparam logic [2:0]         AL_INVALID_FIRST = 3'd5;
	localparam logic [2:0]         AL_INVALID_LAST  = 3'd7;

	typedef struct {
		item_action_t            action;
		logic [2:0]              alarm_state;
		logic [2:0]              vent_state;
		logic signed [FlowW-1:0] o2_flow;
		logic [Fio2W-1:0]        fio2_setting;
		logic                    full_o2_active;
	} leak_item_t;

	// ------------------------------------------------------------------
	// DUT connections, inputs at known values from time zero
	// ------------------------------------------------------------------
	logic                    clk            = 1'b0;
	logic                    arst_n         = 1'b0;
	logic                    in_valid       = 1'b0;
	logic                    in_ready;
	logic                    action         = 1'b0;
	logic [2:0]              alarm_state    = '0;
	logic [2:0]              vent_state     = '0;
	logic signed [FlowW-1:0] o2_flow        = '0;
	logic [Fio2W-1:0]        fio2_setting   = '0;
	logic                    full_o2_active = 1'b0;
	logic                    out_valid;
	logic                    out_ready      = 1'b0;
	logic [1:0]              alarm_action;
	logic                    state_error;
	logic                    cfg_valid      = 1'b0;
	logic                    cfg_ready;
	logic [CfgIdxW-1:0]      cfg_index      = '0;
	logic [CfgDatW-1:0]      cfg_data       = '0;

	oxygen_leak_alarm_qualifier i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.action         (action),
		.alarm_state    (alarm_state),
		.vent_state     (vent_state),
		.o2_flow        (o2_flow),
		.fio2_setting   (fio2_setting),
		.full_o2_active (full_o2_active),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.alarm_action   (alarm_action),
		.state_error    (state_error),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	// ------------------------------------------------------------------
	// Bench state
	// ------------------------------------------------------------------
	leak_item_t   item_q[$];      // items waiting to be offered
	olaq_result_t verdict_q[$];   // verdicts still owed by the block
	leak_item_t   on_wire;        // item currently presented on the input
	olaq_result_t verdict;
	olaq_result_t want;

	// predictor's own copy of registers and state
	logic signed [FlowW-1:0] thr_cfg       = LEAK_THRESHOLD_RST;
	logic [Fio2W-1:0]        fio2_min_cfg  = FIO2_MINIMUM_RST;
	logic [HoldW-1:0]        hold_cfg      = HOLD_TICKS_RST;
	logic signed [FlowW-1:0] peak_mdl      = '0;
	logic [2:0]              last_vent_mdl = VENT_DISABLED;
	logic [HoldW-1:0]        hold_left_mdl = '0;

	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;
	int rx_hold_seq  = 0;   // bumped by the sequencer to request a hold-off
	int rx_hold_seen = 0;
	int rx_hold_left = 0;
	int fail_cnt     = 0;
	int cycle_cnt    = 0;
	int pushed       = 0;

	int thr_tab  [NUM_SETTINGS] = '{-32768, 32767, 50, 120, -15, 0};
	int min_tab  [NUM_SETTINGS] = '{0, 100, 21, 40, 60, 21};
	int hold_tab [NUM_SETTINGS] = '{0, 65535, 3, 7, 1, 12};

	always #HALF_PERIOD clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor: one item in, at most one verdict out.
	// Peak is cleared on an inspiration that follows exhalation, then
	// tracks the largest flow seen while inspiring. FiO2 above minimum
	// reloads the hold timer before the alarm decision reads it.
	// ------------------------------------------------------------------
	function automatic bit qualify_leak(input leak_item_t it, output olaq_result_t res);
		logic insp_now;
		logic insp_last;
		logic fio2_on;
		logic end_of_insp;
		res = '0;
		if (it.action == ACT_TICK) begin
			if (hold_left_mdl != '0)
				hold_left_mdl--;
			return 1'b0;
		end
		insp_now  = it.vent_state == VENT_INSP_CTRL || it.vent_state == VENT_INSP_TRIG;
		insp_last = last_vent_mdl == VENT_INSP_CTRL || last_vent_mdl == VENT_INSP_TRIG;
		if (insp_now && last_vent_mdl == VENT_EXHALE)
			peak_mdl = '0;
		if (insp_now && it.o2_flow > peak_mdl)
			peak_mdl = it.o2_flow;
		fio2_on = it.fio2_setting > fio2_min_cfg;
		if (fio2_on)
			hold_left_mdl = hold_cfg;
		end_of_insp = it.vent_state == VENT_EXHALE && insp_last;
		res.alarm_action = ALARM_NONE;
		case (it.alarm_state)
		AL_FALSE: begin
			if ((peak_mdl >= thr_cfg && !it.full_o2_active && !fio2_on &&
			     hold_left_mdl == '0 && end_of_insp) ||
			    (it.vent_state == VENT_DISABLED && it.o2_flow > thr_cfg))
				res.alarm_action = ALARM_RAISE;
		end
		AL_DISPLAYED: begin
			if ((peak_mdl < thr_cfg && end_of_insp) ||
			    (fio2_on && it.vent_state != VENT_DISABLED) || it.full_o2_active ||
			    (it.o2_flow <= thr_cfg && it.vent_state == VENT_DISABLED))
				res.alarm_action = ALARM_END;
		end
		AL_TRUE: ;
		default: res.state_error = 1'b1;   // detected, cancelled or invalid
		endcase
		last_vent_mdl = it.vent_state;
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic void push_eval(input logic [2:0] al, input logic [2:0] vent,
	                                  input int flow, input int fio2, input bit full);
		leak_item_t it;
		it.action         = ACT_EVAL;
		it.alarm_state    = al;
		it.vent_state     = vent;
		it.o2_flow        = 16'(flow);
		it.fio2_setting   = 7'(fio2);
		it.full_o2_active = full;
		item_q.push_back(it);
		pushed++;
	endfunction

	// ticks carry random junk in the unused fields
	function automatic void push_tick();
		leak_item_t it;
		it.action         = ACT_TICK;
		it.alarm_state    = 3'($urandom);
		it.vent_state     = 3'($urandom);
		it.o2_flow        = 16'($urandom);
		it.fio2_setting   = 7'($urandom_range(0, 100));
		it.full_o2_active = 1'($urandom);
		item_q.push_back(it);
		pushed++;
	endfunction

	function automatic logic [2:0] pick_alarm();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return AL_FALSE;
		if (r < 70)
			return AL_DISPLAYED;
		if (r < 85)
			return AL_TRUE;
		return 3'($urandom);
	endfunction

	// mostly close to the threshold, sometimes anywhere, sometimes at the rails
	function automatic int pick_flow();
		int r;
		int f;
		r = $urandom_range(0, 99);
		if (r < 4)
			return -32768;
		if (r < 8)
			return 32767;
		if (r < 20)
			return int'($signed(16'($urandom)));
		f = int'(thr_cfg) + int'($urandom_range(0, 80)) - 40;
		if (f > 32767)
			f = 32767;
		if (f < -32768)
			f = -32768;
		return f;
	endfunction

	// mostly at or below the minimum so that the raise path stays reachable
	function automatic int pick_fio2();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(0, int'(fio2_min_cfg));
		return $urandom_range(0, 100);
	endfunction

	function automatic bit pick_full();
		return $urandom_range(0, 99) < 10;
	endfunction

	// One breath: inspiration samples, then exhalation, with ticks between.
	// A share of the time it is a disabled stretch or pure noise instead.
	function automatic void queue_breath();
		int kind;
		kind = $urandom_range(0, 99);
		if (kind < 10) begin
			repeat ($urandom_range(1, 4)) begin
				if ($urandom_range(0, 1))
					push_tick();
				else
					push_eval(3'($urandom), 3'($urandom), int'($signed(16'($urandom))),
					          $urandom_range(0, 100), 1'($urandom));
			end
			return;
		end
		if (kind < 20) begin
			repeat ($urandom_range(1, 3))
				push_eval(pick_alarm(), VENT_DISABLED, pick_flow(), pick_fio2(), pick_full());
			return;
		end
		repeat ($urandom_range(1, 6)) begin
			push_eval(pick_alarm(), $urandom_range(0, 1) ? VENT_INSP_CTRL : VENT_INSP_TRIG,
			          pick_flow(), pick_fio2(), pick_full());
			if ($urandom_range(0, 99) < 20)
				push_tick();
		end
		repeat ($urandom_range(1, 3)) begin
			push_eval(pick_alarm(), VENT_EXHALE, pick_flow(), pick_fio2(), pick_full());
			if ($urandom_range(0, 99) < 20)
				push_tick();
		end
		if (kind < 30)
			push_eval(pick_alarm(), 3'($urandom_range(VENT_OTHER_FIRST, VENT_OTHER_LAST)),
			          pick_flow(), pick_fio2(), pick_full());
		repeat ($urandom_range(0, 6))
			push_tick();
	endfunction

	// Writes all three registers plus the spare index, holding valid high
	// across the sequence so it is dropped only once at the end.
	task automatic apply_cfg(input int thr, input int fmin, input int hold);
		logic [CfgIdxW-1:0] idx_list [4];
		logic [CfgDatW-1:0] val_list [4];
		idx_list = '{CFG_LEAK_THRESHOLD, CFG_FIO2_MINIMUM, CFG_HOLD_TICKS, CFG_SPARE};
		val_list = '{16'(thr), 16'(fmin), 16'(hold), 16'($urandom)};
		for (int i = 0; i < 4; i++) begin
			cfg_index <= idx_list[i];
			cfg_data  <= val_list[i];
			cfg_valid <= 1'b1;
			do @(posedge clk); while (!cfg_ready);
			case (idx_list[i])
			CFG_LEAK_THRESHOLD: thr_cfg      = val_list[i];
			CFG_FIO2_MINIMUM:   fio2_min_cfg = val_list[i][Fio2W-1:0];
			CFG_HOLD_TICKS:     hold_cfg     = val_list[i];
			default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	// block is idle once nothing is queued, offered or owed; ticks leave no
	// result behind, so wait out the idle gap as well before touching registers
	task automatic wait_idle();
		while (item_q.size() != 0 || in_valid || verdict_q.size() != 0)
			@(posedge clk);
		repeat (IDLE_GAP) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Input driver: predicts on every transfer, then offers the next item
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				if (qualify_leak(on_wire, verdict))
					verdict_q.push_back(verdict);
			end
			if (!in_valid || in_ready) begin
				if (item_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
					on_wire = item_q.pop_front();
					action         <= on_wire.action;
					alarm_state    <= on_wire.alarm_state;
					vent_state     <= on_wire.vent_state;
					o2_flow        <= on_wire.o2_flow;
					fio2_setting   <= on_wire.fio2_setting;
					full_o2_active <= on_wire.full_o2_active;
					in_valid       <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver hold-off: a request from the sequencer blocks out_ready
	// for a long stretch while the driver keeps offering items
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_hold_left <= 0;
			rx_hold_seen <= 0;
		end else if (rx_hold_seen != rx_hold_seq) begin
			rx_hold_left <= RX_HOLD_CYCLES;
			rx_hold_seen <= rx_hold_seq;
		end else if (rx_hold_left != 0) begin
			rx_hold_left <= rx_hold_left - 1;
		end
	end

	// ------------------------------------------------------------------
	// Result monitor: every transfer is matched to the oldest verdict
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (verdict_q.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= MAX_REPORTS)
						$display("%0t: result with none owed: action %0d error %0d",
						         $time, alarm_action, state_error);
				end else begin
					want = verdict_q.pop_front();
					if (alarm_action !== want.alarm_action ||
					    state_error !== want.state_error) begin
						fail_cnt++;
						if (fail_cnt <= MAX_REPORTS)
							$display("%0t: mismatch: action exp %0d got %0d, error exp %0d got %0d",
							         $time, want.alarm_action, alarm_action,
							         want.state_error, state_error);
					end
				end
			end
			out_ready <= rx_hold_left == 0 && $urandom_range(0, 99) >= rx_stall_pct;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pass on reset registers: threshold 50, minimum 21, hold 10000
		push_eval(AL_FALSE, VENT_INSP_CTRL, 120, 21, 1'b0);       // peak builds, FiO2 at minimum
		push_eval(AL_FALSE, VENT_EXHALE, 0, 0, 1'b0);             // end of inspiration: raise
		push_eval(AL_DISPLAYED, VENT_INSP_TRIG, 10, 0, 1'b0);     // new breath clears peak
		push_eval(AL_DISPLAYED, VENT_EXHALE, 0, 0, 1'b0);         // low peak ends alarm
		push_eval(AL_FALSE, VENT_DISABLED, 51, 0, 1'b0);          // disabled, above threshold
		push_eval(AL_FALSE, VENT_DISABLED, 50, 0, 1'b0);          // strict compare: no raise
		push_eval(AL_DISPLAYED, VENT_DISABLED, 50, 0, 1'b0);      // disabled, at threshold: end
		push_eval(AL_DISPLAYED, VENT_INSP_CTRL, -32768, 100, 1'b0); // FiO2 on: end, timer reload
		push_eval(AL_DISPLAYED, VENT_OTHER_FIRST, 32767, 0, 1'b1);  // full oxygen: end
		repeat (3) push_tick();
		push_eval(AL_FALSE, VENT_INSP_TRIG, 32767, 0, 1'b0);
		push_eval(AL_FALSE, VENT_EXHALE, 0, 0, 1'b0);             // timer still running: no raise
		push_eval(AL_TRUE, VENT_EXHALE, 0, 0, 1'b0);
		push_eval(AL_DETECTED, VENT_INSP_CTRL, 0, 0, 1'b0);
		push_eval(AL_CANCELED, VENT_EXHALE, 0, 0, 1'b0);
		for (int a = AL_INVALID_FIRST; a <= AL_INVALID_LAST; a++)
			push_eval(3'(a), 3'(a), -1, 100, 1'b1);
		push_eval(AL_DISPLAYED, VENT_DISABLED, 32767, 100, 1'b0); // FiO2 on but disabled
		wait_idle();

		// random breaths over several register settings and idle profiles
		for (int c = 0; c < NUM_CHUNKS; c++) begin
			case (c / 3)
			0: begin
				tx_idle_pct  = 14;
				rx_stall_pct = 78;
			end
			1: begin
				tx_idle_pct  = 78;
				rx_stall_pct = 14;
			end
			default: begin
				tx_idle_pct  = 0;
				rx_stall_pct = 0;
			end
			endcase
			apply_cfg(thr_tab[c % NUM_SETTINGS], min_tab[c % NUM_SETTINGS],
			          hold_tab[c % NUM_SETTINGS]);
			pushed = 0;
			while (pushed < CHUNK_ITEMS)
				queue_breath();
			rx_hold_seq++;
			// sender stops here until every verdict of the chunk is back
			wait_idle();
		end

		if (fail_cnt == 0 && verdict_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* files.f */
src/olaq_pkg.sv
src/olaq_eval.sv
src/oxygen_leak_alarm_qualifier.sv
src/olaq_checker.sv
sim/tb_top.sv
